// File: rtl/core/led_ripple_idle_animator_macros.svh
// Assertion helpers for the ripple animator.
`ifndef LED_RIPPLE_IDLE_ANIMATOR_MACROS_SVH
`define LED_RIPPLE_IDLE_ANIMATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ripple animator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ripple animator check failed");

`endif

// File: rtl/core/lra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lra_pkg;

    localparam int NUM_SLOTS_DEF = 3;
    localparam int SPAWN_SHIFT   = 7;
    localparam int STEP_MUL      = 24;
    localparam int LEVEL_MAX     = 63;
    localparam int PHASE_MAX     = 126;
    localparam int PIX_LAST      = 63;

    // Per-tick broadcast to every cell
    typedef struct packed {
        logic        load;
        logic [15:0] now16;
        logic [2:0]  col;
        logic [2:0]  row;
        logic [2:0]  rgb;
    } t_tick;

    // Pixel beat travelling down the chain
    typedef struct packed {
        logic [5:0] idx;
        logic [5:0] red;
        logic [5:0] green;
        logic [5:0] blue;
        logic       last;
    } t_pix;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    // Channel law for a phase inside the visible window
    function automatic logic [5:0] level(input logic lit, input logic [6:0] t);
        logic [6:0] v;
        if (lit) begin
            v = (t <= 7'(LEVEL_MAX)) ? 7'(LEVEL_MAX) : 7'(PHASE_MAX) - t;
        end else begin
            v = (t <= 7'(LEVEL_MAX)) ? 7'(LEVEL_MAX) - t : 7'd0;
        end
        return v[5:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/led_ripple_idle_animator.sv
// The first pixel beat of a tick passes through the register of each slot cell
// before it reaches the output. One pixel beat per cycle while the output is not
// stalled, 64 per tick, scanned through the row of slot cells; no new tick is
// accepted until the last beat has left. Output stall freezes the whole cell chain.
// Reset (synchronous, active low): all slots inactive, ring pointer at the last
// slot, previous time zero, chain empty.
`timescale 1ns / 1ps
`default_nettype none

`include "led_ripple_idle_animator_macros.svh"

module led_ripple_idle_animator #(
    parameter int NUM_SLOTS = lra_pkg::NUM_SLOTS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire [31:0] i_time_ms,
    input  wire [2:0]  i_spawn_x,
    input  wire [2:0]  i_spawn_y,
    input  wire [2:0]  i_spawn_color,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [5:0] o_pixel_index,
    output logic [5:0] o_red,
    output logic [5:0] o_green,
    output logic [5:0] o_blue,
    output logic       o_frame_last
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

    lra_pkg::t_state r_state, n_state;
    logic [31:0]       r_prev_time;
    logic [SLOT_W-1:0] r_next_slot;
    logic [5:0]        r_cnt, n_cnt;

    logic              accept;
    logic              spawn;
    logic [SLOT_W-1:0] new_slot;
    logic              adv;
    logic              inject;
    lra_pkg::t_tick    tick;
    logic [NUM_SLOTS-1:0] sel;

    logic          pix_vld [NUM_SLOTS+1];
    lra_pkg::t_pix pix     [NUM_SLOTS+1];

    assign o_stall = (r_state != lra_pkg::ST_IDLE);
    assign accept  = i_valid && !o_stall;
    assign adv     = !(o_valid && i_stall);

    // Spawn decision and ring advance
    assign spawn    = (r_prev_time[31:lra_pkg::SPAWN_SHIFT] != i_time_ms[31:lra_pkg::SPAWN_SHIFT]);
    assign new_slot = (r_next_slot == SLOT_LAST) ? '0 : r_next_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= 32'd0;
            r_next_slot <= SLOT_LAST;
        end else if (accept) begin
            r_prev_time <= i_time_ms;
            if (spawn) begin
                r_next_slot <= new_slot;
            end
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lra_pkg::ST_IDLE;
            r_cnt   <= 6'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        inject  = 1'b0;
        case (r_state)
            lra_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = lra_pkg::ST_SCAN;
                    n_cnt   = 6'd0;
                end
            end
            lra_pkg::ST_SCAN: begin
                inject = 1'b1;
                if (adv) begin
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'(lra_pkg::PIX_LAST)) begin
                        n_state = lra_pkg::ST_DRAIN;
                    end
                end
            end
            lra_pkg::ST_DRAIN: begin
                if (o_valid && !i_stall && o_frame_last) begin
                    n_state = lra_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lra_pkg::ST_IDLE;
            end
        endcase
    end

    // Tick broadcast
    always_comb begin
        tick.load  = accept;
        tick.now16 = i_time_ms[15:0];
        tick.col   = i_spawn_x;
        tick.row   = i_spawn_y;
        tick.rgb   = i_spawn_color;
    end

    // Chain head: black pixel at the scan position
    assign pix_vld[0]   = inject;
    assign pix[0].idx   = r_cnt;
    assign pix[0].red   = 6'd0;
    assign pix[0].green = 6'd0;
    assign pix[0].blue  = 6'd0;
    assign pix[0].last  = (r_cnt == 6'(lra_pkg::PIX_LAST));

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        assign sel[k] = spawn && (new_slot == SLOT_W'(k));

        lra_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (adv),
            .i_tick    (tick),
            .i_sel     (sel[k]),
            .i_pix_vld (pix_vld[k]),
            .i_pix     (pix[k]),
            .o_pix_vld (pix_vld[k+1]),
            .o_pix     (pix[k+1])
        );
    end

    // Last cell register is the output register
    assign o_valid       = pix_vld[NUM_SLOTS];
    assign o_pixel_index = pix[NUM_SLOTS].idx;
    assign o_red         = pix[NUM_SLOTS].red;
    assign o_green       = pix[NUM_SLOTS].green;
    assign o_blue        = pix[NUM_SLOTS].blue;
    assign o_frame_last  = pix[NUM_SLOTS].last;

    // Checks
    `LRA_ASSERT_NOW(a_idle_empty, i_clk, i_rst_n, !o_stall, !o_valid)
    `LRA_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, accept,
        (r_state == lra_pkg::ST_SCAN) && (r_cnt == 6'd0))
    `LRA_ASSERT_NOW(a_last_drain, i_clk, i_rst_n, o_valid && o_frame_last,
        r_state == lra_pkg::ST_DRAIN)
    `LRA_ASSERT_NEXT(a_contiguous, i_clk, i_rst_n, o_valid && !i_stall && !o_frame_last,
        o_valid && (o_pixel_index == $past(o_pixel_index) + 6'd1))

endmodule

`default_nettype wire

// File: rtl/core/lra_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lra_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_adv,
    input  wire lra_pkg::t_tick i_tick,
    input  wire                 i_sel,
    input  wire                 i_pix_vld,
    input  wire lra_pkg::t_pix  i_pix,
    output logic                o_pix_vld,
    output lra_pkg::t_pix       o_pix
);

    localparam logic [7:0] STEP_MUL_W = 8'(lra_pkg::STEP_MUL);

    logic        r_active;
    logic [15:0] r_start;
    logic [2:0]  r_col;
    logic [2:0]  r_row;
    logic [2:0]  r_rgb;
    logic [15:0] r_age;
    logic        r_pix_vld;
    lra_pkg::t_pix r_pix;
    lra_pkg::t_pix n_pix;

    logic [15:0] start_use;
    logic [2:0]  px;
    logic [2:0]  py;
    logic        on_row;
    logic        on_col;
    logic [2:0]  gap;
    logic [7:0]  gap24;
    logic [15:0] phase;
    logic        hit;

    // Slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_tick.load && i_sel) begin
            r_active <= 1'b1;
        end
    end

    // Slot contents and age; only the low 16 bits of age matter
    assign start_use = i_sel ? {i_tick.now16[15:7], 7'd0} : r_start;

    always_ff @(posedge i_clk) begin
        if (i_tick.load) begin
            r_age <= i_tick.now16 - start_use;
            if (i_sel) begin
                r_start <= start_use;
                r_col   <= i_tick.col;
                r_row   <= i_tick.row;
                r_rgb   <= i_tick.rgb;
            end
        end
    end

    // Coverage test and phase for the incoming pixel
    assign px     = i_pix.idx[4:2];
    assign py     = {i_pix.idx[5], i_pix.idx[1:0]};
    assign on_row = (py == r_row);
    assign on_col = (px == r_col);

    always_comb begin
        if (on_row) begin
            gap = (px >= r_col) ? px - r_col : r_col - px;
        end else begin
            gap = (py >= r_row) ? py - r_row : r_row - py;
        end
    end

    assign gap24  = STEP_MUL_W * {5'd0, gap};
    assign phase  = r_age - {8'd0, gap24};
    assign hit    = r_active && (on_row || on_col) && (phase <= 16'(lra_pkg::PHASE_MAX));

    // Later cells overwrite earlier ones
    always_comb begin
        n_pix = i_pix;
        if (hit) begin
            n_pix.red   = lra_pkg::level(r_rgb[2], phase[6:0]);
            n_pix.green = lra_pkg::level(r_rgb[1], phase[6:0]);
            n_pix.blue  = lra_pkg::level(r_rgb[0], phase[6:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_vld <= 1'b0;
        end else if (i_adv) begin
            r_pix_vld <= i_pix_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix_vld = r_pix_vld;
    assign o_pix     = r_pix;

endmodule

`default_nettype wire
